// ===== design/lidar_occupancy_grid_assert.svh =====
// assertion macros for the lidar occupancy grid checker
// no dependencies; included by design/locg_checker.sv
`ifndef LIDAR_OCCUPANCY_GRID_ASSERT_SVH
`define LIDAR_OCCUPANCY_GRID_ASSERT_SVH

// property checked while reset is low
`define LOCG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define LOCG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/locg_pkg.sv =====
// shared types, codes and the cos/sin table of the lidar occupancy grid
// no dependencies; used by every module of the block
package locg_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COORD_W = 20;
   localparam int QUEUE_DEPTH = 2;
   localparam int TRIG_ENTRIES = 256;
   localparam int TRIG_W = 17;
   localparam int TAYLOR_TERMS = 15;

   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_LIMIT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_WEIGHT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EDGE_WEIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CORNER_WEIGHT = 3'd4;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_PLOT = 2'd2,
      CMD_READ = 2'd3
   } cmd_kind_type;

   // command from front to back: hit cell of a sample, or the cell to read
   typedef struct packed {
      cmd_kind_type kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } grid_cmd_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic [7:0] center;
      logic [7:0] edge_w;
      logic [7:0] corner;
   } cfg_weights_type;

   // each entry: sin in the upper half, cos in the lower, both signed q1.15
   typedef logic [TRIG_ENTRIES-1:0][2*TRIG_W-1:0] trig_tab_type;

   localparam logic [63:0] Q28_ONE = 64'd268435456;
   localparam logic [63:0] PI_Q28 = 64'd843314857;

   // n*(n+1) divisors of the cosine and sine series
   localparam logic [63:0] COS_DIV [TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
      64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870};
   localparam logic [63:0] SIN_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930};

   function automatic logic signed [TRIG_W-1:0] q28_to_q15(input logic signed [63:0] v);
      logic neg;
      logic [63:0] mag;
      neg = v[63];
      mag = neg ? 64'(-v) : 64'(v);
      mag = (mag + 64'd4096) >> 13;
      if (mag > 64'd32768) begin
         mag = 64'd32768;
      end
      return neg ? -$signed(mag[TRIG_W-1:0]) : $signed(mag[TRIG_W-1:0]);
   endfunction

   function automatic logic signed [63:0] taylor(input logic [63:0] first,
                                                 input logic [63:0] t2,
                                                 input logic is_sin);
      logic [63:0] term;
      logic signed [63:0] sum;
      term = first;
      sum = $signed(first);
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         if (is_sin) begin
            term = ((term * t2) >> 28) / SIN_DIV[k];
         end else begin
            term = ((term * t2) >> 28) / COS_DIV[k];
         end
         if ((k % 2) == 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return sum;
   endfunction

   function automatic trig_tab_type build_trig_tab();
      trig_tab_type tab;
      logic [63:0] theta;
      logic [63:0] t2;
      logic flip;
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
      for (int i = 0; i < TRIG_ENTRIES; i++) begin
         theta = (64'(i) * 64'd314 * Q28_ONE + 64'd9000) / 64'd18000;
         flip = 1'b0;
         if (theta >= PI_Q28) begin
            theta = theta - PI_Q28;
            flip = 1'b1;
         end
         t2 = (theta * theta) >> 28;
         c = q28_to_q15(taylor(Q28_ONE, t2, 1'b0));
         s = q28_to_q15(taylor(theta, t2, 1'b1));
         if (flip) begin
            c = -c;
            s = -s;
         end
         tab[i] = {s, c};
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();

endpackage

// ===== design/locg_front.sv =====
// front end: accepts requests, looks up cos/sin and maps a sample to its grid cell
// depends on locg_pkg; feeds locg_queue
module locg_front #(
   parameter int GRID_WIDTH = 40,
   parameter int SCAN_POINTS = 180,
   parameter int CELL_SIZE = 200
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] req_opcode,
   input  logic [15:0] req_distance,
   input  logic [7:0] req_angle_index,
   input  logic [5:0] req_cell_x,
   input  logic [4:0] req_cell_y,
   input  logic [15:0] range_limit,
   input  logic hold,
   input  logic cmd_full,
   output logic cmd_push,
   output locg_pkg::grid_cmd_type cmd
);

   localparam int TW = locg_pkg::TRIG_W;
   localparam int CW = locg_pkg::COORD_W;
   localparam int PROD_W = 2 * TW;
   localparam int Q15_SHIFT = 15;
   localparam int SHIFT_W = PROD_W - Q15_SHIFT;
   localparam int QUO_IN_W = 17;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W = 30;
   localparam int QUO_PROD_W = QUO_IN_W + RECIP_W;
   localparam longint RECIP_VAL =
      ((longint'(1) << RECIP_SHIFT) + longint'(CELL_SIZE) - 1) / longint'(CELL_SIZE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic signed [CW-1:0] X_OFFSET = CW'(GRID_WIDTH / 2);

   // floor shift by 2^15, then magnitude ready for floor division by the cell size
   function automatic logic [QUO_IN_W:0] floor_prep(input logic signed [PROD_W-1:0] p);
      logic signed [SHIFT_W-1:0] s;
      logic [QUO_IN_W-1:0] mag;
      s = p[PROD_W-1:Q15_SHIFT];
      mag = QUO_IN_W'(-s);
      return {s[SHIFT_W-1],
              s[SHIFT_W-1] ? mag + QUO_IN_W'(CELL_SIZE - 1) : s[QUO_IN_W-1:0]};
   endfunction

   function automatic logic signed [CW-1:0] apply_sign(input logic neg,
                                                       input logic [QUO_IN_W-1:0] q);
      logic signed [CW-1:0] m;
      m = CW'(q);
      return neg ? -m : m;
   endfunction

   logic advance;
   logic [2*TW-1:0] trig;

   logic s1_valid_ff, s1_valid_in;
   locg_pkg::opcode_type s1_op_ff;
   logic s1_ok_ff;
   logic [15:0] s1_dist_ff;
   logic signed [TW-1:0] s1_cos_ff, s1_sin_ff;
   logic [5:0] s1_cx_ff;
   logic [4:0] s1_cy_ff;

   logic s2_valid_ff;
   locg_pkg::opcode_type s2_op_ff;
   logic s2_ok_ff;
   logic [5:0] s2_cx_ff;
   logic [4:0] s2_cy_ff;
   logic signed [PROD_W-1:0] s2_pc_ff, s2_pc_in;
   logic signed [PROD_W-1:0] s2_ps_ff, s2_ps_in;

   logic s3_valid_ff;
   locg_pkg::opcode_type s3_op_ff;
   logic s3_ok_ff;
   logic [5:0] s3_cx_ff;
   logic [4:0] s3_cy_ff;
   logic [QUO_IN_W:0] prep_x, prep_y;
   logic [QUO_PROD_W-1:0] s3_qx_ff, s3_qx_in;
   logic [QUO_PROD_W-1:0] s3_qy_ff, s3_qy_in;
   logic s3_nx_ff, s3_ny_ff;

   assign advance = !(s3_valid_ff && cmd_full);
   assign req_tready = advance && !hold;
   assign s1_valid_in = req_tvalid && req_tready;
   assign trig = locg_pkg::TRIG_TAB[req_angle_index];

   assign s2_pc_in = $signed({1'b0, s1_dist_ff}) * s1_cos_ff;
   assign s2_ps_in = $signed({1'b0, s1_dist_ff}) * s1_sin_ff;

   assign prep_x = floor_prep(s2_pc_ff);
   assign prep_y = floor_prep(s2_ps_ff);
   assign s3_qx_in = QUO_PROD_W'(prep_x[QUO_IN_W-1:0]) * QUO_PROD_W'(RECIP);
   assign s3_qy_in = QUO_PROD_W'(prep_y[QUO_IN_W-1:0]) * QUO_PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= locg_pkg::opcode_type'(req_opcode);
         s1_ok_ff <= (req_distance < range_limit) &&
                     (9'(req_angle_index) < 9'(SCAN_POINTS));
         s1_dist_ff <= req_distance;
         s1_cos_ff <= trig[TW-1:0];
         s1_sin_ff <= trig[2*TW-1:TW];
         s1_cx_ff <= req_cell_x;
         s1_cy_ff <= req_cell_y;

         s2_op_ff <= s1_op_ff;
         s2_ok_ff <= s1_ok_ff;
         s2_cx_ff <= s1_cx_ff;
         s2_cy_ff <= s1_cy_ff;
         s2_pc_ff <= s2_pc_in;
         s2_ps_ff <= s2_ps_in;

         s3_op_ff <= s2_op_ff;
         s3_ok_ff <= s2_ok_ff;
         s3_cx_ff <= s2_cx_ff;
         s3_cy_ff <= s2_cy_ff;
         s3_qx_ff <= s3_qx_in;
         s3_qy_ff <= s3_qy_in;
         s3_nx_ff <= prep_x[QUO_IN_W];
         s3_ny_ff <= prep_y[QUO_IN_W];
      end
   end

   assign cmd_push = s3_valid_ff && !cmd_full;

   always_comb begin
      cmd.x = CW'(s3_cx_ff);
      cmd.y = CW'(s3_cy_ff);
      unique case (s3_op_ff)
         locg_pkg::OP_CLEAR: begin
            cmd.kind = locg_pkg::CMD_CLEAR;
         end
         locg_pkg::OP_SAMPLE: begin
            cmd.kind = s3_ok_ff ? locg_pkg::CMD_PLOT : locg_pkg::CMD_NONE;
            cmd.x = apply_sign(s3_nx_ff, s3_qx_ff[RECIP_SHIFT+QUO_IN_W-1:RECIP_SHIFT])
                    + X_OFFSET;
            cmd.y = apply_sign(s3_ny_ff, s3_qy_ff[RECIP_SHIFT+QUO_IN_W-1:RECIP_SHIFT]);
         end
         locg_pkg::OP_READ: begin
            cmd.kind = locg_pkg::CMD_READ;
         end
         default: begin
            cmd.kind = locg_pkg::CMD_NONE;
         end
      endcase
   end

endmodule

// ===== design/locg_queue.sv =====
// two-entry command queue between front and back end
// depends on locg_pkg
module locg_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  locg_pkg::grid_cmd_type din,
   output logic full,
   input  logic pop,
   output logic valid,
   output locg_pkg::grid_cmd_type dout
);

   localparam int PTR_W = $clog2(locg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(locg_pkg::QUEUE_DEPTH + 1);

   locg_pkg::grid_cmd_type entry_ff [locg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = count_ff == CNT_W'(locg_pkg::QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign dout = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== design/locg_back.sv =====
// back end: grid memory, neighbourhood read-modify-write, clear sweep and cell readout
// depends on locg_pkg; takes commands from locg_queue
module locg_back #(
   parameter int GRID_WIDTH = 40,
   parameter int GRID_HEIGHT = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  locg_pkg::grid_cmd_type cmd,
   output logic cmd_pop,
   input  locg_pkg::cfg_weights_type weights,
   output logic init_busy,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_value,
   output logic rsp_plotted
);

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);
   localparam int CW = locg_pkg::COORD_W;
   localparam logic signed [CW-1:0] X_LIMIT = CW'(GRID_WIDTH);
   localparam logic signed [CW-1:0] Y_LIMIT = CW'(GRID_HEIGHT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [3:0] STEP_CENTER = 4'd4;
   localparam logic [3:0] STEP_LAST = 4'd8;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PLOT,
      ST_READ,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [3:0] step_ff, step_in;
   locg_pkg::grid_cmd_type cmd_ff, cmd_in;
   logic hit_ff, hit_in;
   logic wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0] wr_weight_ff, wr_weight_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic rsp_plotted_ff, rsp_plotted_in;

   logic [15:0] grid_mem [DEPTH];
   logic [15:0] rd_data_ff;

   logic signed [1:0] dx, dy;
   logic [7:0] weight;
   logic signed [CW-1:0] nx, ny;
   logic in_grid;
   logic [ADDR_W-1:0] addr;
   logic rd_en;
   logic mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0] mem_wdata;
   logic [16:0] sat_sum;
   logic out_free;
   logic start;
   logic [15:0] read_value;

   // 3x3 walk, row by row from the upper left
   always_comb begin
      unique case (step_ff)
         4'd0: begin dx = -2'sd1; dy = -2'sd1; weight = weights.corner; end
         4'd1: begin dx = 2'sd0; dy = -2'sd1; weight = weights.edge_w; end
         4'd2: begin dx = 2'sd1; dy = -2'sd1; weight = weights.corner; end
         4'd3: begin dx = -2'sd1; dy = 2'sd0; weight = weights.edge_w; end
         4'd5: begin dx = 2'sd1; dy = 2'sd0; weight = weights.edge_w; end
         4'd6: begin dx = -2'sd1; dy = 2'sd1; weight = weights.corner; end
         4'd7: begin dx = 2'sd0; dy = 2'sd1; weight = weights.edge_w; end
         4'd8: begin dx = 2'sd1; dy = 2'sd1; weight = weights.corner; end
         default: begin dx = 2'sd0; dy = 2'sd0; weight = weights.center; end
      endcase
   end

   assign nx = cmd_ff.x + CW'(dx);
   assign ny = cmd_ff.y + CW'(dy);
   assign in_grid = (nx >= 0) && (nx < X_LIMIT) && (ny >= 0) && (ny < Y_LIMIT);
   assign addr = ADDR_W'(ny[YW-1:0]) * ADDR_W'(GRID_WIDTH) + ADDR_W'(nx[XW-1:0]);

   assign rd_en = ((state_ff == ST_PLOT) || (state_ff == ST_READ)) && in_grid;
   assign sat_sum = {1'b0, rd_data_ff} + 17'(wr_weight_ff);
   assign read_value = (rd_data_ff > weights.threshold) ?
                       rd_data_ff - weights.threshold : 16'd0;

   always_comb begin
      mem_we = wr_pend_ff;
      mem_waddr = wr_addr_ff;
      mem_wdata = sat_sum[16] ? 16'hFFFF : sat_sum[15:0];
      if ((state_ff == ST_INIT) || (state_ff == ST_CLEAR)) begin
         mem_we = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[addr];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign start = cmd_valid &&
                  ((state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free));
   assign cmd_pop = start;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      step_in = step_ff;
      cmd_in = cmd_ff;
      hit_in = hit_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = addr;
      wr_weight_in = weight;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_plotted_in = rsp_plotted_ff;

      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end
         end
         ST_PLOT: begin
            wr_pend_in = in_grid;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            hit_in = in_grid;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ((cmd_ff.kind == locg_pkg::CMD_READ) && hit_ff) ?
                              read_value : 16'd0;
               rsp_plotted_in = cmd_ff.kind == locg_pkg::CMD_PLOT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start) begin
         cmd_in = cmd;
         sweep_in = '0;
         step_in = '0;
         unique case (cmd.kind)
            locg_pkg::CMD_CLEAR: state_in = ST_CLEAR;
            locg_pkg::CMD_PLOT: state_in = ST_PLOT;
            locg_pkg::CMD_READ: begin
               state_in = ST_READ;
               step_in = STEP_CENTER;
            end
            default: state_in = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         wr_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         wr_pend_ff <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      cmd_ff <= cmd_in;
      hit_ff <= hit_in;
      wr_addr_ff <= wr_addr_in;
      wr_weight_ff <= wr_weight_in;
      rsp_value_ff <= rsp_value_in;
      rsp_plotted_ff <= rsp_plotted_in;
   end

   assign init_busy = state_ff == ST_INIT;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_plotted = rsp_plotted_ff;

endmodule

// ===== design/lidar_occupancy_grid.sv =====
// top level of the lidar occupancy grid: control registers, front end, queue, back end
// depends on locg_pkg, locg_front, locg_queue and locg_back
//
// Builds a GRID_WIDTH x GRID_HEIGHT grid of saturating 16-bit hit counters from lidar
// range samples. Each request carries an opcode in req_tuser: clear the grid, add a
// sample (distance and whole-degree angle), or read one cell (value minus threshold,
// floored at zero). Every request returns exactly one response in order. A sample
// below range_limit with an angle below SCAN_POINTS is mapped to cell
// x = floor(d*cos/(32768*CELL_SIZE)) + GRID_WIDTH/2, y = floor(d*sin/(32768*CELL_SIZE))
// and adds center, edge and corner weights to its 3x3 neighbourhood; neighbours off
// the grid are skipped. The front end takes a request every cycle, unless a full
// queue or the post-reset sweep stalls it, into a three-stage pipeline (table lookup,
// multiply, reciprocal multiply) and a two-entry queue. The back end is bound by the
// grid memory with one read and one write port: a sample makes nine overlapped reads
// and read-modify-writes, a read one read, a clear a sweep over every cell, and each
// request then ends in a result step. After reset the grid is zeroed by a sweep over
// all GRID_WIDTH*GRID_HEIGHT cells during which req_tready stays low; control registers
// can still be written. Write control registers only while the block is idle.
module lidar_occupancy_grid #(
   parameter int GRID_WIDTH = 40,
   parameter int GRID_HEIGHT = 20,
   parameter int SCAN_POINTS = 180,
   parameter int CELL_SIZE = 200
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [locg_pkg::REQ_TDATA_W-1:0] req_tdata, // distance, angle_index, cell_x, cell_y
   input  logic [1:0] req_tuser,                       // opcode
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [locg_pkg::RSP_TDATA_W-1:0] rsp_tdata, // cell_value, sample_plotted
   // control register write port
   input  logic csr_we,
   input  logic [locg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [locg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // control registers
   logic [15:0] range_limit_ff;
   logic [15:0] threshold_ff;
   logic [7:0] center_weight_ff;
   logic [7:0] edge_weight_ff;
   logic [7:0] corner_weight_ff;
   locg_pkg::cfg_weights_type weights;

   // front to queue to back
   logic hold;
   logic cmd_push;
   logic cmd_full;
   logic cmd_pop;
   logic cmd_valid;
   locg_pkg::grid_cmd_type cmd_front;
   locg_pkg::grid_cmd_type cmd_back;

   logic [15:0] rsp_value;
   logic rsp_plotted;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_limit_ff <= 16'd4000;
         threshold_ff <= 16'd40;
         center_weight_ff <= 8'd12;
         edge_weight_ff <= 8'd3;
         corner_weight_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            locg_pkg::CSR_RANGE_LIMIT: range_limit_ff <= csr_wdata;
            locg_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            locg_pkg::CSR_CENTER_WEIGHT: center_weight_ff <= csr_wdata[7:0];
            locg_pkg::CSR_EDGE_WEIGHT: edge_weight_ff <= csr_wdata[7:0];
            locg_pkg::CSR_CORNER_WEIGHT: corner_weight_ff <= csr_wdata[7:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   assign weights.threshold = threshold_ff;
   assign weights.center = center_weight_ff;
   assign weights.edge_w = edge_weight_ff;
   assign weights.corner = corner_weight_ff;

   // front end: request fields unpacked from the lowest bit up
   locg_front #(
      .GRID_WIDTH(GRID_WIDTH),
      .SCAN_POINTS(SCAN_POINTS),
      .CELL_SIZE(CELL_SIZE)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_opcode(req_tuser),
      .req_distance(req_tdata[15:0]),
      .req_angle_index(req_tdata[23:16]),
      .req_cell_x(req_tdata[29:24]),
      .req_cell_y(req_tdata[34:30]),
      .range_limit(range_limit_ff),
      .hold(hold),
      .cmd_full(cmd_full),
      .cmd_push(cmd_push),
      .cmd(cmd_front)
   );

   // decouples the pipelined front from the multi-cycle back end
   locg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .din(cmd_front),
      .full(cmd_full),
      .pop(cmd_pop),
      .valid(cmd_valid),
      .dout(cmd_back)
   );

   // back end owns the grid memory and the response register
   locg_back #(
      .GRID_WIDTH(GRID_WIDTH),
      .GRID_HEIGHT(GRID_HEIGHT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd_back),
      .cmd_pop(cmd_pop),
      .weights(weights),
      .init_busy(hold),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_value(rsp_value),
      .rsp_plotted(rsp_plotted)
   );

   // response fields packed from the lowest bit up, zero padded to whole bytes
   assign rsp_tdata = {(locg_pkg::RSP_TDATA_W - 17)'(0), rsp_plotted, rsp_value};

endmodule

// ===== design/locg_checker.sv =====
// port-level assertions for the lidar occupancy grid, bound to the top level
// depends on lidar_occupancy_grid_assert.svh and lidar_occupancy_grid
`include "lidar_occupancy_grid_assert.svh"

module locg_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a stalled response keeps its payload
   `LOCG_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // a plotted sample never carries a cell value
   `LOCG_ASSERT(a_plot_no_value, clock, reset, rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == 16'd0, "plotted response with nonzero cell value")

   // the grid clearing sweep blocks requests right after reset
   `LOCG_ASSERT_ALWAYS(a_init_blocks_req, clock, reset |=> !req_tready, "request accepted during grid clearing sweep")

   // no response left over from before reset
   `LOCG_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_tvalid, "response valid right after reset")

endmodule

bind lidar_occupancy_grid locg_checker u_locg_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

// ===== tb/tb_lidar_occupancy_grid.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the lidar occupancy grid: stream stimulus, grid scoreboard
// depends on locg_pkg and lidar_occupancy_grid
module tb_lidar_occupancy_grid;

   // block size at the default parameters
   localparam int GRID_W = 40;
   localparam int GRID_H = 20;
   localparam int GRID_CELLS = GRID_W * GRID_H;
   localparam int SCAN_POINTS = 180;
   localparam int CELL_SIZE = 200;

   // opcode with no operation behind it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // fixed point constants of the cos/sin table
   localparam longint unsigned Q28_UNIT = 64'd268435456;
   localparam longint unsigned HALF_TURN_Q28 = 64'd843314857;
   localparam int SERIES_TERMS = 15;

   // quiet cycles after the last response before a register write or the end
   localparam int SETTLE_CYCLES = 16;
   // length of the one long receiver hold-off
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct {
      logic [1:0] opcode;
      logic [15:0] distance;
      logic [7:0] angle;
      logic [5:0] cell_x;
      logic [4:0] cell_y;
   } grid_req_type;

   typedef struct {
      logic [15:0] cell_value;
      logic sample_plotted;
   } grid_rsp_type;

   // own copy of the grid and registers; predicts one response per request
   class grid_scoreboard;
      int errors;
      int last_hit_x;
      int last_hit_y;
      logic [15:0] range_limit;
      logic [15:0] threshold;
      logic [7:0] center_w;
      logic [7:0] edge_w;
      logic [7:0] corner_w;
      logic [15:0] cells [GRID_CELLS];
      int cos_q [SCAN_POINTS];
      int sin_q [SCAN_POINTS];
      grid_rsp_type pending_readouts [$];

      function new();
         longint unsigned theta;
         longint unsigned t2;
         bit flip;
         int c;
         int s;
         for (int i = 0; i < SCAN_POINTS; i++) begin
            theta = (longint'(i) * 314 * Q28_UNIT + 9000) / 18000;
            flip = 1'b0;
            if (theta >= HALF_TURN_Q28) begin
               theta = theta - HALF_TURN_Q28;
               flip = 1'b1;
            end
            t2 = (theta * theta) >> 28;
            c = round_q15(trig_series(Q28_UNIT, t2, 1));
            s = round_q15(trig_series(theta, t2, 2));
            cos_q[i] = flip ? -c : c;
            sin_q[i] = flip ? -s : s;
         end
         errors = 0;
         last_hit_x = GRID_W / 2;
         last_hit_y = 0;
         range_limit = 16'd4000;
         threshold = 16'd40;
         center_w = 8'd12;
         edge_w = 8'd3;
         corner_w = 8'd1;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      // alternating taylor series in q28, n0 = 1 for cosine, 2 for sine
      function longint trig_series(longint unsigned first, longint unsigned t2,
                                   longint unsigned n0);
         longint unsigned term;
         longint unsigned n;
         longint sum;
         term = first;
         sum = longint'(first);
         n = n0;
         for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * t2) >> 28) / (n * (n + 1));
            n = n + 2;
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         return sum;
      endfunction

      function int round_q15(longint v);
         bit neg;
         longint unsigned mag;
         neg = v < 0;
         mag = neg ? longint'(-v) : longint'(v);
         mag = (mag + 4096) >> 13;
         if (mag > 32768) begin
            mag = 32768;
         end
         return neg ? -int'(mag) : int'(mag);
      endfunction

      function longint floor_div(longint num, longint den);
         if (num >= 0) begin
            return num / den;
         end
         return -((-num + den - 1) / den);
      endfunction

      function void write_reg(logic [locg_pkg::CSR_ADDR_W-1:0] addr, logic [15:0] value);
         case (addr)
            locg_pkg::CSR_RANGE_LIMIT: range_limit = value;
            locg_pkg::CSR_THRESHOLD: threshold = value;
            locg_pkg::CSR_CENTER_WEIGHT: center_w = value[7:0];
            locg_pkg::CSR_EDGE_WEIGHT: edge_w = value[7:0];
            locg_pkg::CSR_CORNER_WEIGHT: corner_w = value[7:0];
            default: ;
         endcase
      endfunction

      // saturating add, cells off the grid are skipped
      function void add_weight(longint x, longint y, logic [7:0] w);
         int idx;
         int sum;
         if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) begin
            return;
         end
         idx = int'(y) * GRID_W + int'(x);
         sum = int'(cells[idx]) + int'(w);
         cells[idx] = (sum > 65535) ? 16'hffff : 16'(sum);
      endfunction

      function void note_request(grid_req_type rq);
         grid_rsp_type rsp;
         longint den;
         longint hx;
         longint hy;
         int idx;
         rsp.cell_value = '0;
         rsp.sample_plotted = 1'b0;
         den = longint'(32768) * CELL_SIZE;
         case (rq.opcode)
            locg_pkg::OP_CLEAR: begin
               foreach (cells[i]) cells[i] = '0;
            end
            locg_pkg::OP_SAMPLE: begin
               if (rq.distance < range_limit && rq.angle < SCAN_POINTS) begin
                  hx = floor_div(longint'(rq.distance) * cos_q[rq.angle], den) + GRID_W / 2;
                  hy = floor_div(longint'(rq.distance) * sin_q[rq.angle], den);
                  for (int dy = -1; dy <= 1; dy++) begin
                     for (int dx = -1; dx <= 1; dx++) begin
                        if (dx == 0 && dy == 0) begin
                           add_weight(hx, hy, center_w);
                        end else if (dx == 0 || dy == 0) begin
                           add_weight(hx + dx, hy + dy, edge_w);
                        end else begin
                           add_weight(hx + dx, hy + dy, corner_w);
                        end
                     end
                  end
                  rsp.sample_plotted = 1'b1;
                  last_hit_x = int'(hx);
                  last_hit_y = int'(hy);
               end
            end
            locg_pkg::OP_READ: begin
               if (rq.cell_x < GRID_W && rq.cell_y < GRID_H) begin
                  idx = int'(rq.cell_y) * GRID_W + int'(rq.cell_x);
                  rsp.cell_value = (cells[idx] > threshold) ? cells[idx] - threshold : '0;
               end
            end
            default: ;
         endcase
         pending_readouts.push_back(rsp);
      endfunction

      function void check_response(logic [locg_pkg::RSP_TDATA_W-1:0] tdata);
         grid_rsp_type exp_rsp;
         if (pending_readouts.size() == 0) begin
            $error("response 0x%0h with no request waiting", tdata);
            errors++;
            return;
         end
         exp_rsp = pending_readouts.pop_front();
         if (tdata[15:0] !== exp_rsp.cell_value) begin
            $error("cell_value: expected %0d, actual %0d", exp_rsp.cell_value, tdata[15:0]);
            errors++;
         end
         if (tdata[16] !== exp_rsp.sample_plotted) begin
            $error("sample_plotted: expected %0d, actual %0d", exp_rsp.sample_plotted,
                   tdata[16]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [locg_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [locg_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [locg_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [locg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   grid_scoreboard sb = new();

   // requests left in the current sender burst
   int burst_left = 0;
   // set by the stimulus to make the receiver hold off for a long stretch
   bit start_holdoff = 1'b0;

   lidar_occupancy_grid i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("lidar_occupancy_grid test failed");
      $finish;
   end

   // response side: check every accepted response, then pick the next ready
   initial begin : rsp_sink
      int style;
      int style_left;
      int hold_left;
      style = 0;
      style_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
         end
         if (start_holdoff) begin
            hold_left = HOLDOFF_CYCLES;
            start_holdoff = 1'b0;
         end
         if (hold_left > 0) begin
            // long hold-off so the queue and the front end back up
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 3);
               style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
               0: rsp_tready <= 1'b1;                            // no stalls
               1: rsp_tready <= ($urandom_range(0, 3) != 0);     // light stalls
               2: rsp_tready <= (style_left % 3 == 0);           // ready when style_left is a multiple of 3
               default: rsp_tready <= ($urandom_range(0, 9) < 3); // heavy stalls
            endcase
         end
      end
   end

   function automatic grid_req_type make_req(logic [1:0] op, logic [15:0] distance,
                                             logic [7:0] ang, logic [5:0] cx,
                                             logic [4:0] cy);
      grid_req_type rq;
      rq.opcode = op;
      rq.distance = distance;
      rq.angle = ang;
      rq.cell_x = cx;
      rq.cell_y = cy;
      return rq;
   endfunction

   // offer one request in bursts with random gaps, note it once accepted
   task automatic send_request(input grid_req_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      // tdata from bit 0: distance, angle_index, cell_x, cell_y
      req_tdata <= {5'd0, rq.cell_y, rq.cell_x, rq.angle, rq.distance};
      req_tuser <= rq.opcode;
      do @(posedge clock); while (!req_tready);
      sb.note_request(rq);
      burst_left--;
   endtask

   // stop offering, let every response come back and the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_readouts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all five control registers, one per cycle
   task automatic program_csr(input logic [15:0] rl, input logic [15:0] th,
                              input logic [7:0] cw, input logic [7:0] ew,
                              input logic [7:0] kw);
      logic [locg_pkg::CSR_ADDR_W-1:0] addrs [5] = '{locg_pkg::CSR_RANGE_LIMIT,
                                                     locg_pkg::CSR_THRESHOLD,
                                                     locg_pkg::CSR_CENTER_WEIGHT,
                                                     locg_pkg::CSR_EDGE_WEIGHT,
                                                     locg_pkg::CSR_CORNER_WEIGHT};
      logic [15:0] vals [5];
      vals = '{rl, th, 16'(cw), 16'(ew), 16'(kw)};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
         sb.write_reg(addrs[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // random requests; hammer keeps hitting one cell to drive it into saturation
   task automatic random_phase(input int n_items, input bit hammer, input int holdoff_at);
      grid_req_type rq;
      int r;
      int hx;
      int hy;
      for (int i = 0; i < n_items; i++) begin
         if (i == holdoff_at) begin
            start_holdoff = 1'b1;
         end
         // unused fields carry noise on every op
         rq = make_req(locg_pkg::OP_READ, 16'($urandom), 8'($urandom), 6'($urandom),
                       5'($urandom));
         r = $urandom_range(0, 99);
         if (!hammer && r < 1) begin
            rq.opcode = locg_pkg::OP_CLEAR;
         end else if (r < 3) begin
            rq.opcode = OP_UNUSED;
         end else if (r < (hammer ? 80 : 58)) begin
            rq.opcode = locg_pkg::OP_SAMPLE;
            r = $urandom_range(0, 99);
            if (hammer && r < 90) begin
               rq.distance = 16'd1000;
               rq.angle = 8'(30 + $urandom_range(0, 1));
            end else if (r < 85) begin
               // mostly hits that land on the grid
               rq.distance = 16'($urandom_range(0, 4500));
               rq.angle = 8'($urandom_range(0, SCAN_POINTS - 1));
            end else if (r < 93) begin
               rq.angle = 8'($urandom_range(0, SCAN_POINTS - 1));
            end else if (r < 97) begin
               // right around the range limit
               rq.distance = sb.range_limit + 16'($urandom_range(0, 4)) - 16'd2;
               rq.angle = 8'($urandom_range(0, SCAN_POINTS - 1));
            end else begin
               rq.distance = 16'($urandom_range(0, 4500));
               rq.angle = 8'($urandom_range(SCAN_POINTS, 255));
            end
         end else begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
               // around the latest hit so reads see nonzero cells
               hx = sb.last_hit_x + int'($urandom_range(0, 2)) - 1;
               hy = sb.last_hit_y + int'($urandom_range(0, 2)) - 1;
               hx = (hx < 0) ? 0 : (hx >= GRID_W) ? GRID_W - 1 : hx;
               hy = (hy < 0) ? 0 : (hy >= GRID_H) ? GRID_H - 1 : hy;
               rq.cell_x = 6'(hx);
               rq.cell_y = 5'(hy);
            end else if (r < 9) begin
               rq.cell_x = 6'($urandom_range(0, GRID_W - 1));
               rq.cell_y = 5'($urandom_range(0, GRID_H - 1));
            end
         end
         send_request(rq);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset register values; first request waits out the clear sweep
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd0, 5'd0));
      // origin hit, lower neighbours fall below the grid
      repeat (4) send_request(make_req(locg_pkg::OP_SAMPLE, 16'd0, 8'd0, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd20, 5'd0));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd21, 5'd0));
      // right edge, top edge, left edge with a negative floor
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd3999, 8'd0, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd3999, 8'd90, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd3999, 8'd179, 6'd0, 5'd0));
      // tiny negative x rounds down one column
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd1, 8'd91, 6'd0, 5'd0));
      // distance at the limit, far out of range, angles past SCAN_POINTS
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd4000, 8'd45, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'hffff, 8'd179, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd100, 8'd180, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd100, 8'd255, 6'd0, 5'd0));
      // unused opcode with every field bit set
      send_request(make_req(OP_UNUSED, 16'hffff, 8'hff, 6'h3f, 5'h1f));
      // reads off the grid and at its far corner
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'h3f, 5'h1f));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd40, 5'd0));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd0, 5'd20));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd39, 5'd19));
      send_request(make_req(locg_pkg::OP_CLEAR, 16'd0, 8'd0, 6'd0, 5'd0));
      send_request(make_req(locg_pkg::OP_READ, 16'd0, 8'd0, 6'd20, 5'd0));
      send_request(make_req(locg_pkg::OP_SAMPLE, 16'd2000, 8'd45, 6'd0, 5'd0));

      random_phase(350, 1'b0, -1);
      wait_idle();

      // extremes: everything in range, no threshold, full weights, saturate one cell
      program_csr(16'hffff, 16'd0, 8'hff, 8'hff, 8'hff);
      random_phase(400, 1'b1, -1);
      wait_idle();

      // nothing in range, threshold at the top, zero weights
      program_csr(16'd0, 16'hffff, 8'd0, 8'd0, 8'd0);
      random_phase(150, 1'b0, -1);
      wait_idle();

      // random settings; the first one includes the long receiver hold-off
      for (int p = 0; p < 3; p++) begin
         program_csr(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 300)),
                     8'($urandom_range(0, (p == 1) ? 255 : 40)),
                     8'($urandom_range(0, (p == 2) ? 255 : 20)),
                     8'($urandom_range(0, 255)));
         random_phase(250, 1'b0, (p == 0) ? 100 : -1);
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("lidar_occupancy_grid test passed");
      end else begin
         $display("lidar_occupancy_grid test failed");
      end
      $finish;
   end

endmodule
